@@ hw/rtl/ted_pkg.sv @@
// ----------------------------------------------------------------------------
// ted_pkg
// Shared types and constants for the text encoding detector.
// ----------------------------------------------------------------------------
package ted_pkg;

	// Default sample limit in bytes
	localparam int unsigned MAX_SAMPLE_DEF = 8192;

	// Depth of the request queue between front and back
	localparam int unsigned QUEUE_DEPTH = 2;

	typedef enum logic [3:0] {
		ENC_UTF8    = 4'd0,
		ENC_UTF16LE = 4'd1,
		ENC_UTF16BE = 4'd2,
		ENC_UTF32LE = 4'd3,
		ENC_UTF32BE = 4'd4,
		ENC_LATIN1  = 4'd5,
		ENC_CP437   = 4'd6,
		ENC_CP850   = 4'd7,
		ENC_BINARY  = 4'd8
	} enc_t;

	typedef struct packed {
		enc_t       encoding;
		logic [2:0] bom_length;
	} res_t;

endpackage

@@ hw/rtl/ted_front.sv @@
// ----------------------------------------------------------------------------
// ted_front
// Takes one byte per request, keeps the running statistics and pushes a
// snapshot of them into the queue when the last byte arrives.
// ----------------------------------------------------------------------------
module ted_front #(
	parameter int unsigned MAX_SAMPLE = ted_pkg::MAX_SAMPLE_DEF,
	parameter int unsigned CNT_W      = 14,
	parameter int unsigned NUL_W      = 13,
	parameter int unsigned SNAP_W     = 32 + 6 * CNT_W + 2 * NUL_W + 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        data_byte,
	input  logic              last_byte,
	input  logic              q_full,
	output logic              q_push,
	output logic [SNAP_W-1:0] q_data
);

	logic [31:0]      head_q, head_n;
	logic [CNT_W-1:0] n_q, n_n;
	logic [CNT_W-1:0] ctrl_q, ctrl_n;
	logic [NUL_W-1:0] even_q, even_n;
	logic [NUL_W-1:0] odd_q, odd_n;
	logic [1:0]       pend_q, pend_n;
	logic             bad_q, bad_n;
	logic [CNT_W-1:0] high_q, high_n;
	logic             dos_q, dos_n;
	logic [CNT_W-1:0] box_q, box_n;
	logic [CNT_W-1:0] latin_q, latin_n;
	logic [CNT_W-1:0] greek_q, greek_n;
	logic             take;
	logic             accept;
	logic             utf8_ok;

	assign in_stall = q_full;
	assign accept   = in_valid && !in_stall;
	assign take     = n_q < CNT_W'(MAX_SAMPLE);

	always_comb begin
		head_n  = head_q;
		n_n     = n_q;
		ctrl_n  = ctrl_q;
		even_n  = even_q;
		odd_n   = odd_q;
		pend_n  = pend_q;
		bad_n   = bad_q;
		high_n  = high_q;
		dos_n   = dos_q;
		box_n   = box_q;
		latin_n = latin_q;
		greek_n = greek_q;
		if (take) begin
			// first four bytes, offset 0 in the top byte
			if (n_q[CNT_W-1:2] == '0) begin
				case (n_q[1:0])
					2'd0: head_n[31:24] = data_byte;
					2'd1: head_n[23:16] = data_byte;
					2'd2: head_n[15:8]  = data_byte;
					default: head_n[7:0] = data_byte;
				endcase
			end
			if (data_byte inside {[8'h01:8'h07], [8'h0E:8'h1F]})
				ctrl_n = ctrl_q + CNT_W'(1);
			if (data_byte == 8'h00) begin
				if (n_q[0])
					odd_n = odd_q + NUL_W'(1);
				else
					even_n = even_q + NUL_W'(1);
			end
			// UTF-8 structure check
			if (pend_q != 2'd0) begin
				if (data_byte[7:6] == 2'b10)
					pend_n = pend_q - 2'd1;
				else
					bad_n = 1'b1;
			end else if (data_byte[7]) begin
				if (data_byte[7:5] == 3'b110)
					pend_n = 2'd1;
				else if (data_byte[7:4] == 4'b1110)
					pend_n = 2'd2;
				else if (data_byte[7:3] == 5'b11110)
					pend_n = 2'd3;
				else
					bad_n = 1'b1;
			end
			if (data_byte[7]) begin
				high_n = high_q + CNT_W'(1);
				// bytes unused in Latin-1 text
				if (data_byte inside {8'h81, 8'h8D, 8'h8F, 8'h90})
					dos_n = 1'b1;
				if (data_byte inside {[8'hB0:8'hCF]})
					box_n = box_q + CNT_W'(1);
				if (data_byte inside {[8'hD0:8'hDF]})
					latin_n = latin_q + CNT_W'(1);
				if (data_byte inside {[8'hE0:8'hEF]})
					greek_n = greek_q + CNT_W'(1);
			end
			n_n = n_q + CNT_W'(1);
		end
	end

	assign utf8_ok = !bad_n && (pend_n == 2'd0);
	assign q_push  = accept && last_byte;
	assign q_data  = {head_n, n_n, ctrl_n, even_n, odd_n, utf8_ok,
		high_n, dos_n, box_n, latin_n, greek_n};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			n_q     <= '0;
			ctrl_q  <= '0;
			even_q  <= '0;
			odd_q   <= '0;
			pend_q  <= '0;
			bad_q   <= 1'b0;
			high_q  <= '0;
			dos_q   <= 1'b0;
			box_q   <= '0;
			latin_q <= '0;
			greek_q <= '0;
		end else if (accept) begin
			if (last_byte) begin
				head_q  <= '0;
				n_q     <= '0;
				ctrl_q  <= '0;
				even_q  <= '0;
				odd_q   <= '0;
				pend_q  <= '0;
				bad_q   <= 1'b0;
				high_q  <= '0;
				dos_q   <= 1'b0;
				box_q   <= '0;
				latin_q <= '0;
				greek_q <= '0;
			end else begin
				head_q  <= head_n;
				n_q     <= n_n;
				ctrl_q  <= ctrl_n;
				even_q  <= even_n;
				odd_q   <= odd_n;
				pend_q  <= pend_n;
				bad_q   <= bad_n;
				high_q  <= high_n;
				dos_q   <= dos_n;
				box_q   <= box_n;
				latin_q <= latin_n;
				greek_q <= greek_n;
			end
		end
	end

`ifndef ASSERT_OFF
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(n_q <= CNT_W'(MAX_SAMPLE)) && (ctrl_q <= n_q) && (high_q <= n_q))
		else $error("sample counters out of range");
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |=> (n_q == '0) && (pend_q == 2'd0) && !bad_q)
		else $error("statistics not cleared after last byte");
`endif

endmodule

@@ hw/rtl/ted_queue.sv @@
// ----------------------------------------------------------------------------
// ted_queue
// Short request queue between the byte front end and the classifier.
// ----------------------------------------------------------------------------
module ted_queue #(
	parameter int unsigned DATA_W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] push_data,
	input  logic              pop,
	output logic              full,
	output logic              valid,
	output logic [DATA_W-1:0] head_data
);

	localparam int unsigned DEPTH = ted_pkg::QUEUE_DEPTH;
	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push, do_pop;

	assign full      = count_q == CNT_W'(DEPTH);
	assign valid     = count_q != '0;
	assign head_data = mem_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && valid;

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			if (do_push && !do_pop)
				count_q <= count_q + CNT_W'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - CNT_W'(1);
		end
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("push into full queue");
`endif

endmodule

@@ hw/rtl/ted_back.sv @@
// ----------------------------------------------------------------------------
// ted_back
// Classifier: turns a statistics snapshot into the encoding result through
// a compare stage and an output register.
// ----------------------------------------------------------------------------
module ted_back #(
	parameter int unsigned CNT_W  = 14,
	parameter int unsigned NUL_W  = 13,
	parameter int unsigned SNAP_W = 32 + 6 * CNT_W + 2 * NUL_W + 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  logic [SNAP_W-1:0] q_data,
	output logic              q_pop,
	output logic              out_valid,
	input  logic              out_stall,
	output ted_pkg::res_t     res
);

	localparam int unsigned WC = CNT_W + 5;

	logic [31:0]      h;
	logic [CNT_W-1:0] n, ctrl, high, box, latin, greek;
	logic [NUL_W-1:0] even, odd;
	logic             utf8_ok, dos;

	logic             hit_c, short_c, bin_c, sig_c, nul_c, le_c, be_c;
	ted_pkg::enc_t    bom_enc_c;
	logic [2:0]       bom_len_c;
	logic [NUL_W:0]   nul_sum;

	logic             valid_s1;
	logic             hit_s1, short_s1, bin_s1, nul_s1, le_s1, be_s1;
	logic             utf8_ok_s1, no_high_s1, dos_s1, cp437_s1;
	ted_pkg::enc_t    bom_enc_s1;
	logic [2:0]       bom_len_s1;

	logic             out_ready, adv_s1;
	ted_pkg::res_t    res_c, res_q;
	logic             out_valid_q;

	assign {h, n, ctrl, even, odd, utf8_ok, high, dos, box, latin, greek} = q_data;

	assign out_ready = !out_valid_q || !out_stall;
	assign adv_s1    = !valid_s1 || out_ready;
	assign q_pop     = q_valid && adv_s1;

	// byte order marks, longest first
	always_comb begin
		hit_c     = 1'b1;
		bom_enc_c = ted_pkg::ENC_UTF8;
		bom_len_c = 3'd0;
		if (n >= CNT_W'(4) && h == 32'hFFFE_0000) begin
			bom_enc_c = ted_pkg::ENC_UTF32LE;
			bom_len_c = 3'd4;
		end else if (n >= CNT_W'(4) && h == 32'h0000_FEFF) begin
			bom_enc_c = ted_pkg::ENC_UTF32BE;
			bom_len_c = 3'd4;
		end else if (n >= CNT_W'(3) && h[31:8] == 24'hEFBBBF) begin
			bom_enc_c = ted_pkg::ENC_UTF8;
			bom_len_c = 3'd3;
		end else if (n >= CNT_W'(2) && h[31:16] == 16'hFFFE) begin
			bom_enc_c = ted_pkg::ENC_UTF16LE;
			bom_len_c = 3'd2;
		end else if (n >= CNT_W'(2) && h[31:16] == 16'hFEFF) begin
			bom_enc_c = ted_pkg::ENC_UTF16BE;
			bom_len_c = 3'd2;
		end else begin
			hit_c = 1'b0;
		end
	end

	// ELF, PNG, PDF, ZIP, GIF, then MZ, gzip, JPEG
	assign sig_c = (h == 32'h7F45_4C46) || (h == 32'h8950_4E47) ||
		(h == 32'h2550_4446) || (h == 32'h504B_0304) || (h == 32'h4749_4638) ||
		(h[31:16] == 16'h4D5A) || (h[31:16] == 16'h1F8B) || (h[31:8] == 24'hFFD8FF);

	// x > n/k  <=>  k*x > n for integer floor division
	assign short_c = n < CNT_W'(2);
	assign bin_c   = (n >= CNT_W'(4)) &&
		(sig_c || (({5'd0, ctrl} << 4) + ({5'd0, ctrl} << 2) > WC'(n)));
	assign nul_sum = {1'b0, even} + {1'b0, odd};
	assign nul_c   = (WC'(nul_sum) << 3) + (WC'(nul_sum) << 1) > WC'(n);
	assign le_c    = {1'b0, odd} > ({1'b0, even} << 1);
	assign be_c    = {1'b0, even} > ({1'b0, odd} << 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (adv_s1)
			valid_s1 <= q_valid;
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			hit_s1     <= hit_c;
			bom_enc_s1 <= bom_enc_c;
			bom_len_s1 <= bom_len_c;
			short_s1   <= short_c;
			bin_s1     <= bin_c;
			nul_s1     <= nul_c;
			le_s1      <= le_c;
			be_s1      <= be_c;
			utf8_ok_s1 <= utf8_ok;
			no_high_s1 <= high == '0;
			dos_s1     <= dos || (({2'd0, box} << 2) > {2'd0, high});
			cp437_s1   <= (greek > latin) && (greek != '0);
		end
	end

	// priority decision
	always_comb begin
		res_c.bom_length = 3'd0;
		res_c.encoding   = ted_pkg::ENC_LATIN1;
		if (hit_s1) begin
			res_c.encoding   = bom_enc_s1;
			res_c.bom_length = bom_len_s1;
		end else if (short_s1)
			res_c.encoding = ted_pkg::ENC_UTF8;
		else if (bin_s1)
			res_c.encoding = ted_pkg::ENC_BINARY;
		else if (nul_s1 && le_s1)
			res_c.encoding = ted_pkg::ENC_UTF16LE;
		else if (nul_s1 && be_s1)
			res_c.encoding = ted_pkg::ENC_UTF16BE;
		else if (utf8_ok_s1 || no_high_s1)
			res_c.encoding = ted_pkg::ENC_UTF8;
		else if (dos_s1)
			res_c.encoding = cp437_s1 ? ted_pkg::ENC_CP437 : ted_pkg::ENC_CP850;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_ready)
			out_valid_q <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (out_ready && valid_s1)
			res_q <= res_c;
	end

	assign out_valid = out_valid_q;
	assign res       = res_q;

`ifndef ASSERT_OFF
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !out_ready) |-> !q_pop ##1 valid_s1)
		else $error("compare stage lost a request under stall");
	a_bom_enc: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.bom_length != 3'd0) |->
		(res_q.encoding == ted_pkg::ENC_UTF8 || res_q.encoding == ted_pkg::ENC_UTF16LE ||
		res_q.encoding == ted_pkg::ENC_UTF16BE || res_q.encoding == ted_pkg::ENC_UTF32LE ||
		res_q.encoding == ted_pkg::ENC_UTF32BE))
		else $error("byte order mark with non-Unicode encoding");
`endif

endmodule

@@ hw/rtl/text_encoding_detector_core.sv @@
// ----------------------------------------------------------------------------
// text_encoding_detector_core
// Detects the text encoding and byte order mark of a file sample.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_stall): one sample byte per request, in file
//    order; last_byte marks the final byte of the sample. Bytes beyond
//    MAX_SAMPLE are taken but ignored; their last flag still ends the sample.
//  - Output channel (out_valid/out_stall): one request per sample carrying
//    encoding and bom_length.
//  - Throughput: one byte per cycle while in_stall is low. The front end
//    updates all counters for each byte up to MAX_SAMPLE; a sample ends in a
//    snapshot pushed into a two-entry queue, so a result does not pause input.
//  - Result path: the last byte's snapshot passes through the queue, the
//    compare stage and the output register, and waits behind any older
//    requests the queue holds.
//  - Stall: with the output stalled, the output register, compare stage and
//    queue fill up; once the queue is full, in_stall rises and holds until
//    the classifier drains one entry.
//  - Reset: all counters clear and every stage is emptied; no setup needed.
// ----------------------------------------------------------------------------
module text_encoding_detector_core #(
	parameter int unsigned MAX_SAMPLE = ted_pkg::MAX_SAMPLE_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [3:0] encoding,
	output logic [2:0] bom_length
);

	// byte count reaches MAX_SAMPLE; each NUL parity holds about half of it
	localparam int unsigned CNT_W  = $clog2(MAX_SAMPLE + 1);
	localparam int unsigned NUL_W  = $clog2((MAX_SAMPLE + 1) / 2 + 1);
	localparam int unsigned SNAP_W = 32 + 6 * CNT_W + 2 * NUL_W + 2;

	logic              q_full, q_push, q_valid, q_pop;
	logic [SNAP_W-1:0] q_wdata, q_rdata;
	ted_pkg::res_t     res;

	// byte front end: running statistics per sample
	ted_front #(
		.MAX_SAMPLE (MAX_SAMPLE),
		.CNT_W      (CNT_W),
		.NUL_W      (NUL_W),
		.SNAP_W     (SNAP_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_data    (q_wdata)
	);

	// decouples the byte stream from the classifier
	ted_queue #(
		.DATA_W (SNAP_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.pop       (q_pop),
		.full      (q_full),
		.valid     (q_valid),
		.head_data (q_rdata)
	);

	// classifier and output register
	ted_back #(
		.CNT_W  (CNT_W),
		.NUL_W  (NUL_W),
		.SNAP_W (SNAP_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_data    (q_rdata),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res       (res)
	);

	assign encoding   = res.encoding;
	assign bom_length = res.bom_length;

endmodule

@@ verif/tb_text_encoding_detector_core.sv @@
// ----------------------------------------------------------------------------
// tb_text_encoding_detector_core
// Self-checking bench for the text encoding detector. A queue of sample bytes
// (directed cases first, then structured random samples) feeds a clocked
// driver; a clocked monitor compares each result request against a local
// detector model updated on every accepted byte. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_text_encoding_detector_core;

	localparam int SAMPLE_LIMIT = ted_pkg::MAX_SAMPLE_DEF;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int RANDOM_ITEMS = 1250;
	localparam int DRAIN_CYCLES = 20;

	typedef struct {
		logic [7:0] data;
		logic       is_last;
		bit         wait_idle;   // hold off until every result is back
	} byte_req_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] data_byte = 8'h00;
	logic       last_byte = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [3:0] encoding;
	logic [2:0] bom_length;

	byte_req_t      byte_queue[$];
	logic [7:0]     sample_buf[$];
	ted_pkg::res_t  expected_verdicts[$];

	int cycle_count = 0;
	int samples_sent = 0;
	int results_seen = 0;
	int failures = 0;
	int random_items = 0;

	// detector model state
	logic [31:0] head_word = '0;
	logic [13:0] taken = '0;
	logic [13:0] ctrl_seen = '0;
	logic [12:0] nul_even = '0;
	logic [12:0] nul_odd = '0;
	logic [1:0]  cont_left = '0;
	logic        seq_broken = 1'b0;
	logic [13:0] high_seen = '0;
	logic        dos_seen = 1'b0;
	logic [13:0] box_seen = '0;
	logic [13:0] latin_seen = '0;
	logic [13:0] greek_seen = '0;

	wire no_idle = (cycle_count >= 500) && (cycle_count < 1000);

	text_encoding_detector_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.encoding  (encoding),
		.bom_length(bom_length)
	);

	always #4 clk = ~clk;

	// ---------------------------------------------------------------- model
	function automatic ted_pkg::res_t judge_sample();
		int unsigned    n, ev, od, hi;
		bit             binary;
		ted_pkg::res_t  r;
		n  = taken;
		ev = nul_even;
		od = nul_odd;
		hi = high_seen;
		r.bom_length = 3'd0;
		r.encoding   = ted_pkg::ENC_UTF8;
		binary = (n >= 4) && (head_word == 32'h7F454C46 || head_word == 32'h89504E47 ||
			head_word == 32'h25504446 || head_word == 32'h504B0304 ||
			head_word == 32'h47494638 || head_word[31:16] == 16'h4D5A ||
			head_word[31:16] == 16'h1F8B || head_word[31:8] == 24'hFFD8FF ||
			int'(ctrl_seen) > n / 20);
		if (n >= 4 && head_word == 32'hFFFE0000) begin
			r.bom_length = 3'd4;
			r.encoding   = ted_pkg::ENC_UTF32LE;
		end else if (n >= 4 && head_word == 32'h0000FEFF) begin
			r.bom_length = 3'd4;
			r.encoding   = ted_pkg::ENC_UTF32BE;
		end else if (n >= 3 && head_word[31:8] == 24'hEFBBBF) begin
			r.bom_length = 3'd3;
		end else if (n >= 2 && head_word[31:16] == 16'hFFFE) begin
			r.bom_length = 3'd2;
			r.encoding   = ted_pkg::ENC_UTF16LE;
		end else if (n >= 2 && head_word[31:16] == 16'hFEFF) begin
			r.bom_length = 3'd2;
			r.encoding   = ted_pkg::ENC_UTF16BE;
		end else if (n < 2) begin
			r.encoding = ted_pkg::ENC_UTF8;
		end else if (binary) begin
			r.encoding = ted_pkg::ENC_BINARY;
		end else if (ev + od > n / 10 && od > ev * 2) begin
			r.encoding = ted_pkg::ENC_UTF16LE;
		end else if (ev + od > n / 10 && ev > od * 2) begin
			r.encoding = ted_pkg::ENC_UTF16BE;
		end else if (!seq_broken && cont_left == 2'd0) begin
			r.encoding = ted_pkg::ENC_UTF8;
		end else if (hi == 0) begin
			r.encoding = ted_pkg::ENC_UTF8;
		end else if (dos_seen || int'(box_seen) > hi / 4) begin
			if (greek_seen > latin_seen && greek_seen != 0)
				r.encoding = ted_pkg::ENC_CP437;
			else
				r.encoding = ted_pkg::ENC_CP850;
		end else begin
			r.encoding = ted_pkg::ENC_LATIN1;
		end
		return r;
	endfunction

	task automatic absorb_byte(input logic [7:0] b, input logic fin);
		if (int'(taken) < SAMPLE_LIMIT) begin
			if (taken < 4)
				head_word[8 * (3 - taken[1:0]) +: 8] = b;
			if ((b >= 8'h01 && b <= 8'h07) || (b >= 8'h0E && b <= 8'h1F))
				ctrl_seen++;
			if (b == 8'h00) begin
				if (taken[0])
					nul_odd++;
				else
					nul_even++;
			end
			if (cont_left != 2'd0) begin
				if (b[7:6] == 2'b10)
					cont_left--;
				else
					seq_broken = 1'b1;
			end else if (b[7]) begin
				if (b[7:5] == 3'b110)
					cont_left = 2'd1;
				else if (b[7:4] == 4'b1110)
					cont_left = 2'd2;
				else if (b[7:3] == 5'b11110)
					cont_left = 2'd3;
				else
					seq_broken = 1'b1;
			end
			if (b[7]) begin
				high_seen++;
				if (b == 8'h81 || b == 8'h8D || b == 8'h8F || b == 8'h90)
					dos_seen = 1'b1;
				if (b >= 8'hB0 && b <= 8'hCF) box_seen++;
				if (b >= 8'hD0 && b <= 8'hDF) latin_seen++;
				if (b >= 8'hE0 && b <= 8'hEF) greek_seen++;
			end
			taken++;
		end
		if (fin) begin
			expected_verdicts = {expected_verdicts, judge_sample()};
			head_word = '0; taken = '0; ctrl_seen = '0;
			nul_even = '0; nul_odd = '0; cont_left = '0; seq_broken = 1'b0;
			high_seen = '0; dos_seen = 1'b0; box_seen = '0;
			latin_seen = '0; greek_seen = '0;
		end
	endtask

	// ------------------------------------------------------------ stimulus
	function automatic logic [7:0] text_byte();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 4) return 8'h0A;
		if (r < 6) return 8'h09;
		return 8'($urandom_range(32, 126));
	endfunction

	function automatic logic [7:0] cont_byte();
		return 8'h80 + 8'($urandom_range(0, 63));
	endfunction

	// append one byte to the sample under construction
	task automatic add_byte(input logic [7:0] b);
		sample_buf = {sample_buf, b};
	endtask

	// move sample_buf into the request queue, last flag on the final byte
	task automatic flush_sample(input bit hold);
		byte_req_t req;
		for (int i = 0; i < sample_buf.size(); i++) begin
			req.data      = sample_buf[i];
			req.is_last   = (i == sample_buf.size() - 1);
			req.wait_idle = hold && (i == 0);
			byte_queue = {byte_queue, req};
		end
		sample_buf.delete();
	endtask

	task automatic build_random_sample();
		int unsigned kind, len, sel, mode, bias, k;
		logic [31:0] sig;
		kind = $urandom_range(0, 99);
		if (kind < 10) begin
			// raw noise
			len = $urandom_range(1, 24);
			repeat (len) add_byte(8'($urandom_range(0, 255)));
		end else if (kind < 20) begin
			len = $urandom_range(2, 40);
			repeat (len) add_byte(text_byte());
		end else if (kind < 32) begin
			// byte order marks, sometimes cut short
			case ($urandom_range(0, 4))
				0: sample_buf = '{8'hFF, 8'hFE, 8'h00, 8'h00};
				1: sample_buf = '{8'h00, 8'h00, 8'hFE, 8'hFF};
				2: sample_buf = '{8'hEF, 8'hBB, 8'hBF};
				3: sample_buf = '{8'hFF, 8'hFE};
				default: sample_buf = '{8'hFE, 8'hFF};
			endcase
			if ($urandom_range(0, 99) < 15 && sample_buf.size() > 2)
				void'(sample_buf.pop_back());
			len = $urandom_range(0, 10);
			repeat (len) add_byte(($urandom_range(0, 1) != 0) ? text_byte()
				: 8'($urandom_range(0, 255)));
		end else if (kind < 44) begin
			// binary signatures, left aligned, with a byte count
			sel = $urandom_range(0, 7);
			case (sel)
				0: begin sig = 32'h7F454C46; len = 4; end
				1: begin sig = 32'h89504E47; len = 4; end
				2: begin sig = 32'h25504446; len = 4; end
				3: begin sig = 32'h504B0304; len = 4; end
				4: begin sig = 32'h47494638; len = 4; end
				5: begin sig = 32'h4D5A0000; len = 2; end
				6: begin sig = 32'h1F8B0000; len = 2; end
				default: begin sig = 32'hFFD8FF00; len = 3; end
			endcase
			for (int i = 0; i < len; i++)
				add_byte(sig[31 - 8 * i -: 8]);
			if ($urandom_range(0, 99) < 20) begin
				// fewer than four bytes: no binary test at all
				while (sample_buf.size() > 3) void'(sample_buf.pop_back());
			end else begin
				len = $urandom_range(0, 12);
				repeat (len) add_byte(($urandom_range(0, 1) != 0) ? text_byte()
					: 8'($urandom_range(0, 255)));
			end
		end else if (kind < 54) begin
			// text with control bytes around the 1/20 threshold
			len = $urandom_range(4, 40);
			repeat (len) begin
				sel = $urandom_range(0, 99);
				if (sel < 8)
					add_byte(8'($urandom_range(1, 7)));
				else if (sel < 15)
					add_byte(8'($urandom_range(14, 31)));
				else if (sel < 18)
					add_byte(8'h00);
				else
					add_byte(text_byte());
			end
		end else if (kind < 66) begin
			// UTF-16 without a mark, either byte order
			len = $urandom_range(2, 16);
			mode = $urandom_range(0, 1);
			repeat (len) begin
				sig[7:0]  = text_byte();
				sig[15:8] = ($urandom_range(0, 99) < 10) ? 8'($urandom_range(0, 255)) : 8'h00;
				if (mode == 0) begin
					add_byte(sig[7:0]);
					add_byte(sig[15:8]);
				end else begin
					add_byte(sig[15:8]);
					add_byte(sig[7:0]);
				end
			end
			if ($urandom_range(0, 99) < 20) add_byte(text_byte());
		end else if (kind < 80) begin
			// UTF-8 text: valid, cut off at the end, or broken inside
			len = $urandom_range(1, 12);
			repeat (len) begin
				sel = $urandom_range(0, 3);
				case (sel)
					0: add_byte(text_byte());
					1: add_byte(8'hC0 + 8'($urandom_range(0, 31)));
					2: add_byte(8'hE0 + 8'($urandom_range(0, 15)));
					default: add_byte(8'hF0 + 8'($urandom_range(0, 7)));
				endcase
				repeat (sel) add_byte(cont_byte());
			end
			mode = $urandom_range(0, 9);
			if (mode == 6 || mode == 7) begin
				add_byte(8'hE0 + 8'($urandom_range(0, 15)));
				if (mode == 7) add_byte(cont_byte());
			end else if (mode == 8) begin
				k = $urandom_range(0, sample_buf.size() - 1);
				sample_buf[k] = 8'hF8 + 8'($urandom_range(0, 7));
			end else if (mode == 9) begin
				add_byte(8'hC0 + 8'($urandom_range(0, 31)));
				add_byte(text_byte());
			end
		end else if (kind < 94) begin
			// code page text, weighted toward one class of high byte
			len = $urandom_range(4, 30);
			bias = $urandom_range(0, 4);
			repeat (len) begin
				if ($urandom_range(0, 99) < 45) begin
					add_byte(text_byte());
				end else begin
					sel = ($urandom_range(0, 99) < 60) ? bias : $urandom_range(0, 4);
					case (sel)
						0: add_byte(8'hB0 + 8'($urandom_range(0, 31)));
						1: add_byte(8'hD0 + 8'($urandom_range(0, 15)));
						2: add_byte(8'hE0 + 8'($urandom_range(0, 15)));
						3: begin
							case ($urandom_range(0, 3))
								0: add_byte(8'h81);
								1: add_byte(8'h8D);
								2: add_byte(8'h8F);
								default: add_byte(8'h90);
							endcase
						end
						default: add_byte(8'h80 + 8'($urandom_range(0, 127)));
					endcase
				end
			end
		end else begin
			// one to three bytes, often mark fragments
			len = $urandom_range(1, 3);
			repeat (len) begin
				if ($urandom_range(0, 99) < 30) begin
					case ($urandom_range(0, 5))
						0: add_byte(8'h00);
						1: add_byte(8'hFF);
						2: add_byte(8'hFE);
						3: add_byte(8'hEF);
						4: add_byte(8'hBB);
						default: add_byte(8'hBF);
					endcase
				end else begin
					add_byte(8'($urandom_range(0, 255)));
				end
			end
		end
	endtask

	// -------------------------------------------------------------- driver
	// Presents queued bytes; a stalled request holds its payload. Each byte
	// is fed to the model at the edge that accepts it.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid  <= 1'b0;
			data_byte <= 8'h00;
			last_byte <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				absorb_byte(data_byte, last_byte);
				if (last_byte) samples_sent++;
			end
			if (!in_valid || !in_stall) begin
				if (byte_queue.size() != 0 &&
				    !(byte_queue[0].wait_idle && samples_sent != results_seen) &&
				    (no_idle || $urandom_range(0, 99) >= 33)) begin
					in_valid  <= 1'b1;
					data_byte <= byte_queue[0].data;
					last_byte <= byte_queue[0].is_last;
					byte_queue.delete(0);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------- monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				results_seen <= results_seen + 1;
				if (expected_verdicts.size() == 0) begin
					failures++;
					if (failures <= 10)
						$display("unexpected result: encoding %0d bom %0d", encoding, bom_length);
				end else begin
					if (encoding !== expected_verdicts[0].encoding ||
					    bom_length !== expected_verdicts[0].bom_length) begin
						failures++;
						if (failures <= 10)
							$display("mismatch: encoding exp %0d got %0d, bom exp %0d got %0d",
								expected_verdicts[0].encoding, encoding,
								expected_verdicts[0].bom_length, bom_length);
					end
					expected_verdicts.delete(0);
				end
			end
			out_stall <= !no_idle && ($urandom_range(0, 99) < 33);
		end
	end

	// ------------------------------------------------------------ watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// -------------------------------------------------------------- sequence
	initial begin
		// directed: short samples, every mark, a signature, UTF-8 edge cases
		sample_buf = '{8'h00};                      flush_sample(1'b0);
		sample_buf = '{8'hFF};                      flush_sample(1'b0);
		sample_buf = '{8'hFF, 8'hFE};               flush_sample(1'b0);
		sample_buf = '{8'hFE, 8'hFF};               flush_sample(1'b0);
		sample_buf = '{8'hEF, 8'hBB, 8'hBF};        flush_sample(1'b0);
		sample_buf = '{8'hFF, 8'hFE, 8'h00, 8'h00}; flush_sample(1'b0);
		sample_buf = '{8'h00, 8'h00, 8'hFE, 8'hFF}; flush_sample(1'b0);
		sample_buf = '{8'h7F, 8'h45, 8'h4C, 8'h46}; flush_sample(1'b0);
		// sequence closed by the last byte, then one left open
		sample_buf = '{8'hC3, 8'hA9};               flush_sample(1'b0);
		sample_buf = '{8'hE2, 8'h82};               flush_sample(1'b0);

		// first random sample waits for the directed results to drain
		build_random_sample();
		random_items += sample_buf.size();
		flush_sample(1'b1);
		while (random_items < RANDOM_ITEMS) begin
			build_random_sample();
			random_items += sample_buf.size();
			flush_sample($urandom_range(0, 99) < 3);
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (byte_queue.size() != 0 || in_valid) @(negedge clk);
		while (expected_verdicts.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		failures += expected_verdicts.size();

		if (failures == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

@@ text_encoding_detector_core.f @@
hw/rtl/ted_pkg.sv
hw/rtl/ted_front.sv
hw/rtl/ted_queue.sv
hw/rtl/ted_back.sv
hw/rtl/text_encoding_detector_core.sv
verif/tb_text_encoding_detector_core.sv
